// File: hdl/lgw_pkg.sv
// shared types and constants of the liveness-gated watchdog
// no dependencies; used by every other file of the block but lgw_checker
package lgw_pkg;

  localparam int unsigned SLOTS_DEF     = 8;
  localparam int unsigned TIME_BITS_DEF = 48;

  localparam logic [31:0] FEED_INTERVAL_RST = 32'd1000;
  localparam logic [31:0] TIMEOUT_RST       = 32'd10000;

  // register index, taken from paddr[2]
  localparam logic REG_FEED_INTERVAL = 1'b0;
  localparam logic REG_TIMEOUT       = 1'b1;

  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_REGISTER = 2'd1,
    REQ_ALIVE    = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_BAD_BUDGET  = 2'd1,
    STAT_NO_SLOT     = 2'd2,
    STAT_IGNORED     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_UNFED,
    S_DONE
  } state_t;

  typedef struct packed {
    logic budget;
    logic seen;
  } ram_we_t;

endpackage

// File: hdl/liveness_gated_watchdog_unit.sv
// top level of the liveness-gated watchdog: sequencer, counters, config port
// depends on lgw_pkg, lgw_slot_ram and lgw_silence_cmp
//
// An item is taken when start is high and busy is low; its result appears for one cycle with
// done high, and the receiver cannot stall it. Register and alive items pass through the exec
// and done states, a tick without a check through exec, unfed and done, and a tick that runs a
// check through exec, a read and a compare state per slot visited, a last read if none is
// stale, then unfed and done. The check walks the slots one at a time, stopping at a stale one,
// through the registered read of the slot table and the single silence comparator. The slot
// table needs no clearing after reset. expired is sticky until reset.
module liveness_gated_watchdog_unit #(
  parameter int unsigned SLOTS     = lgw_pkg::SLOTS_DEF,
  parameter int unsigned TIME_BITS = lgw_pkg::TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        req_type,
  input  logic [31:0]       budget_ms,
  input  logic signed [7:0] slot_id,
  output logic              done,
  output logic [1:0]        status,
  output logic [3:0]        slot_index,
  output logic              fed,
  output logic              stale_seen,
  output logic [3:0]        stale_index,
  output logic              expired,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  lgw_pkg::state_t state, state_next;

  logic [31:0]          feed_interval;
  logic [31:0]          timeout;
  logic [TIME_BITS-1:0] uptime;
  logic [CNT_W-1:0]     slots_used;
  logic [31:0]          interval_count;
  logic [31:0]          unfed_count;
  logic                 expired_flag;

  logic [1:0]           req_q;
  logic [31:0]          budget_q;
  logic [7:0]           sid_q;
  logic [CNT_W-1:0]     scan_idx;
  logic                 chk_fed;

  lgw_pkg::ram_we_t     ram_we;
  logic [IDX_W-1:0]     wr_addr;
  logic [31:0]          rd_budget;
  logic [TIME_BITS-1:0] rd_seen;
  logic                 slot_stale;

  logic                 accept;
  logic                 cfg_wr;
  logic [31:0]          interval_inc;
  logic [31:0]          unfed_inc;
  logic                 check_due;
  logic                 sid_valid;

  assign accept = start && !busy;
  assign busy   = (state != lgw_pkg::S_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  assign interval_inc = interval_count + 32'd1;
  assign check_due    = interval_inc >= feed_interval;
  assign unfed_inc    = (unfed_count == '1) ? unfed_count : unfed_count + 32'd1;
  assign sid_valid    = !sid_q[7] && (sid_q < 8'(slots_used));
  assign expired      = expired_flag;

  always_comb begin
    case (paddr[2])
      lgw_pkg::REG_FEED_INTERVAL: prdata = feed_interval;
      lgw_pkg::REG_TIMEOUT:       prdata = timeout;
      default:                    prdata = feed_interval;
    endcase
  end

  lgw_slot_ram #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS),
    .IDX_W     (IDX_W)
  ) u_ram (
    .clk       (clk),
    .we        (ram_we),
    .wr_addr   (wr_addr),
    .wr_budget (budget_q),
    .wr_seen   (uptime),
    .rd_addr   (scan_idx[IDX_W-1:0]),
    .rd_budget (rd_budget),
    .rd_seen   (rd_seen)
  );

  lgw_silence_cmp #(
    .TIME_BITS (TIME_BITS)
  ) u_cmp (
    .uptime    (uptime),
    .checkin   (rd_seen),
    .budget    (rd_budget),
    .stale     (slot_stale)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lgw_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = '0;
    wr_addr    = slots_used[IDX_W-1:0];
    case (state)
      lgw_pkg::S_IDLE: begin
        if (accept) begin
          state_next = lgw_pkg::S_EXEC;
        end
      end
      lgw_pkg::S_EXEC: begin
        state_next = lgw_pkg::S_DONE;
        case (req_q)
          lgw_pkg::REQ_TICK: begin
            state_next = check_due ? lgw_pkg::S_SCAN_RD : lgw_pkg::S_UNFED;
          end
          lgw_pkg::REQ_REGISTER: begin
            if (budget_q != 32'd0 && slots_used < CNT_W'(SLOTS)) begin
              ram_we.budget = 1'b1;
              ram_we.seen   = 1'b1;
            end
          end
          lgw_pkg::REQ_ALIVE: begin
            wr_addr = sid_q[IDX_W-1:0];
            if (sid_valid) begin
              ram_we.seen = 1'b1;
            end
          end
          default: ;
        endcase
      end
      lgw_pkg::S_SCAN_RD: begin
        state_next = (scan_idx >= slots_used) ? lgw_pkg::S_UNFED : lgw_pkg::S_SCAN_CMP;
      end
      lgw_pkg::S_SCAN_CMP: begin
        state_next = slot_stale ? lgw_pkg::S_UNFED : lgw_pkg::S_SCAN_RD;
      end
      lgw_pkg::S_UNFED: begin
        state_next = lgw_pkg::S_DONE;
      end
      lgw_pkg::S_DONE: begin
        state_next = lgw_pkg::S_IDLE;
      end
      default: begin
        state_next = lgw_pkg::S_IDLE;
      end
    endcase
  end

  // control and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      feed_interval  <= lgw_pkg::FEED_INTERVAL_RST;
      timeout        <= lgw_pkg::TIMEOUT_RST;
      uptime         <= '0;
      slots_used     <= '0;
      interval_count <= '0;
      unfed_count    <= '0;
      expired_flag   <= 1'b0;
      done           <= 1'b0;
    end else begin
      done <= (state == lgw_pkg::S_DONE);
      if (cfg_wr) begin
        case (paddr[2])
          lgw_pkg::REG_FEED_INTERVAL: feed_interval <= pwdata;
          lgw_pkg::REG_TIMEOUT:       timeout       <= pwdata;
          default: ;
        endcase
      end
      if (state == lgw_pkg::S_EXEC && req_q == lgw_pkg::REQ_TICK) begin
        uptime         <= uptime + TIME_BITS'(1);
        interval_count <= check_due ? 32'd0 : interval_inc;
      end
      if (ram_we.budget) begin
        slots_used <= slots_used + CNT_W'(1);
      end
      if (state == lgw_pkg::S_UNFED) begin
        if (chk_fed) begin
          unfed_count <= '0;
        end else begin
          unfed_count <= unfed_inc;
          if (unfed_inc >= timeout) begin
            expired_flag <= 1'b1;
          end
        end
      end
    end
  end

  // item capture and result staging
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q       <= req_type;
      budget_q    <= budget_ms;
      sid_q       <= slot_id;
      status      <= lgw_pkg::STAT_OK;
      slot_index  <= '0;
      fed         <= 1'b0;
      stale_seen  <= 1'b0;
      stale_index <= '0;
      chk_fed     <= 1'b0;
      scan_idx    <= '0;
    end
    case (state)
      lgw_pkg::S_EXEC: begin
        case (req_q)
          lgw_pkg::REQ_REGISTER: begin
            if (budget_q == 32'd0) begin
              status <= lgw_pkg::STAT_BAD_BUDGET;
            end else if (slots_used >= CNT_W'(SLOTS)) begin
              status <= lgw_pkg::STAT_NO_SLOT;
            end else begin
              slot_index <= 4'(slots_used[IDX_W-1:0]);
            end
          end
          lgw_pkg::REQ_ALIVE: begin
            if (!sid_valid) begin
              status <= lgw_pkg::STAT_IGNORED;
            end
          end
          default: ;
        endcase
      end
      lgw_pkg::S_SCAN_RD: begin
        // past the last used slot with nothing stale: feed
        if (scan_idx >= slots_used) begin
          chk_fed <= 1'b1;
          fed     <= 1'b1;
        end
      end
      lgw_pkg::S_SCAN_CMP: begin
        if (slot_stale) begin
          stale_seen  <= 1'b1;
          stale_index <= 4'(scan_idx[IDX_W-1:0]);
        end else begin
          scan_idx <= scan_idx + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/lgw_slot_ram.sv
// slot table: silence budget and last check-in time of each slot
// one write port with separate field enables, one registered read port; uses lgw_pkg
module lgw_slot_ram #(
  parameter int unsigned SLOTS     = lgw_pkg::SLOTS_DEF,
  parameter int unsigned TIME_BITS = lgw_pkg::TIME_BITS_DEF,
  parameter int unsigned IDX_W     = 3
) (
  input  logic                 clk,
  input  lgw_pkg::ram_we_t     we,
  input  logic [IDX_W-1:0]     wr_addr,
  input  logic [31:0]          wr_budget,
  input  logic [TIME_BITS-1:0] wr_seen,
  input  logic [IDX_W-1:0]     rd_addr,
  output logic [31:0]          rd_budget,
  output logic [TIME_BITS-1:0] rd_seen
);

  logic [31:0]          budget_mem [SLOTS];
  logic [TIME_BITS-1:0] seen_mem   [SLOTS];

  always_ff @(posedge clk) begin
    if (we.budget) begin
      budget_mem[wr_addr] <= wr_budget;
    end
    if (we.seen) begin
      seen_mem[wr_addr] <= wr_seen;
    end
    rd_budget <= budget_mem[rd_addr];
    rd_seen   <= seen_mem[rd_addr];
  end

endmodule

// File: hdl/lgw_silence_cmp.sv
// shared silence unit: wrapped difference of uptime and last check-in, compared to budget
// used once per scanned slot; uses lgw_pkg for defaults
module lgw_silence_cmp #(
  parameter int unsigned TIME_BITS = lgw_pkg::TIME_BITS_DEF
) (
  input  logic [TIME_BITS-1:0] uptime,
  input  logic [TIME_BITS-1:0] checkin,
  input  logic [31:0]          budget,
  output logic                 stale
);

  logic [TIME_BITS-1:0] silence;

  // subtraction wraps at the uptime width
  assign silence = uptime - checkin;
  assign stale   = silence > TIME_BITS'(budget);

endmodule

// File: hdl/lgw_checker.sv
// port-level checks of the liveness-gated watchdog, bound to the top level
// depends on liveness_gated_watchdog_unit
module lgw_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic fed,
  input logic stale_seen,
  input logic expired
);

  // an accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after an accepted item");

  // a result is shown only once the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // each item gives one result strobe
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe repeated");

  a_fed_or_stale: assert property (@(posedge clk) disable iff (rst)
    done |-> !(fed && stale_seen))
    else $error("fed and stale reported together");

  a_expired_sticky: assert property (@(posedge clk) disable iff (rst)
    expired |=> expired)
    else $error("expiry flag dropped without reset");

endmodule

bind liveness_gated_watchdog_unit lgw_checker u_lgw_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .fed        (fed),
  .stale_seen (stale_seen),
  .expired    (expired)
);
